>>> rtl/sxpk_pkg.sv
// Shared types and constants for the SysEx event packetizer.
// No dependencies; every other file of the block depends on this package.
package sxpk_pkg;

    // Transfer sizing
    localparam int MAX_TRANSFER_BYTES = 64;
    localparam int EVENT_BYTES        = 4;

    // Field widths
    localparam int BYTE_W   = 8;
    localparam int CABLE_W  = 4;
    localparam int CODE_W   = 3;
    localparam int MAXPKT_W = 7;
    localparam int HELD_W   = 2;

    // Fill counter covers the largest fill plus one event packet
    localparam int FILL_W = $clog2(MAX_TRANSFER_BYTES + EVENT_BYTES);
    localparam int CMP_W  = (FILL_W > MAXPKT_W) ? FILL_W : MAXPKT_W;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = MAXPKT_W;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_CABLE  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_MAXPKT = 1'd1;
    localparam logic [MAXPKT_W-1:0]  MAXPKT_RESET   = 7'd64;

    // Code index values
    localparam logic [CODE_W-1:0] CIN_CONTINUE  = 3'h4;
    localparam logic [CODE_W-1:0] CIN_END_ONE   = 3'h5;
    localparam logic [CODE_W-1:0] CIN_END_TWO   = 3'h6;
    localparam logic [CODE_W-1:0] CIN_END_THREE = 3'h7;

    // Held byte counts
    localparam logic [HELD_W-1:0] HELD_NONE = 2'd0;
    localparam logic [HELD_W-1:0] HELD_ONE  = 2'd1;
    localparam logic [HELD_W-1:0] HELD_TWO  = 2'd2;

    // Group queue
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // One finished group of up to three bytes
    typedef struct packed {
        logic [BYTE_W-1:0] b0;
        logic [BYTE_W-1:0] b1;
        logic [BYTE_W-1:0] b2;
        logic [CODE_W-1:0] code;
        logic              last;
    } t_group;

    // Front to queue
    typedef struct packed {
        logic   valid;
        t_group group;
    } t_push;

    // Queue head to back
    typedef struct packed {
        logic   valid;
        t_group group;
    } t_qhead;

endpackage

>>> rtl/sxpk_byte_if.sv
// Input byte channel of the SysEx event packetizer.
// Depends on sxpk_pkg for field widths.
interface sxpk_byte_if;
    logic                        valid;
    logic                        ready;
    logic [sxpk_pkg::BYTE_W-1:0] data_byte;
    logic                        last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

>>> rtl/sxpk_event_if.sv
// Output event packet channel of the SysEx event packetizer.
// Depends on sxpk_pkg for field widths.
interface sxpk_event_if;
    logic                         valid;
    logic                         ready;
    logic [sxpk_pkg::CABLE_W-1:0] cable;
    logic [sxpk_pkg::CODE_W-1:0]  code_index;
    logic [sxpk_pkg::BYTE_W-1:0]  midi_first;
    logic [sxpk_pkg::BYTE_W-1:0]  midi_second;
    logic [sxpk_pkg::BYTE_W-1:0]  midi_third;
    logic                         transfer_end;

    modport source (output valid, output cable, output code_index, output midi_first,
                    output midi_second, output midi_third, output transfer_end,
                    input ready);
    modport sink   (input valid, input cable, input code_index, input midi_first,
                    input midi_second, input midi_third, input transfer_end,
                    output ready);
endinterface

>>> rtl/sxpk_cfg_if.sv
// Configuration write channel of the SysEx event packetizer.
// Depends on sxpk_pkg for index and data widths.
interface sxpk_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [sxpk_pkg::CFG_IDX_W-1:0]  index;
    logic [sxpk_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/sysex_event_packetizer_top.sv
// SysEx event packetizer: accepts one message byte per clock and emits USB-MIDI
// event packets (cable and code index, three data bytes) with a transfer-close flag.
// An event packet reaches o_event through a group queue entry and then the output
// register; bytes are taken one per cycle for as long as the two-entry group queue
// has room, so a stalled output absorbs three groups (the output register plus two
// queue entries) before i_byte.ready drops. The output register passes one packet
// per cycle while o_event.ready is high.
// Configuration writes are taken every cycle and must only be issued while no
// message is in flight.
module sysex_event_packetizer_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    sxpk_byte_if.sink     i_byte,
    sxpk_cfg_if.sink      i_cfg,
    sxpk_event_if.source  o_event
);
    import sxpk_pkg::*;

    t_push  s_push;
    t_qhead s_head;
    logic   s_queue_ready;
    logic   s_pop;

    // Group incoming bytes
    sxpk_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_byte        (i_byte),
        .i_queue_ready (s_queue_ready),
        .o_push        (s_push)
    );

    // Decouple grouping from output
    sxpk_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_push),
        .i_pop   (s_pop),
        .o_ready (s_queue_ready),
        .o_head  (s_head)
    );

    // Track transfer fill and register the output
    sxpk_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .i_head  (s_head),
        .o_pop   (s_pop),
        .o_event (o_event)
    );

    // A final byte always produces an ending group in the same cycle
    a_last_ends_group: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_byte.valid && i_byte.ready && i_byte.last_byte)
        |-> (s_push.valid && s_push.group.code != CIN_CONTINUE))
        else $error("final byte did not produce an ending group");

    // An ending packet always closes the transfer
    a_end_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_event.valid && o_event.code_index != CIN_CONTINUE) |-> o_event.transfer_end)
        else $error("ending packet did not close the transfer");

    // A popped group shows up on the output next cycle
    a_pop_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_pop |=> o_event.valid)
        else $error("popped group missing from output");

    // No group is offered to a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_push.valid |-> s_queue_ready)
        else $error("group pushed into a full queue");

endmodule

>>> rtl/sxpk_front.sv
// Front end: accepts message bytes and groups them into event packet payloads.
// Depends on sxpk_pkg and sxpk_byte_if.
module sxpk_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    sxpk_byte_if.sink        i_byte,
    input  logic             i_queue_ready,
    output sxpk_pkg::t_push  o_push
);
    import sxpk_pkg::*;

    logic [BYTE_W-1:0] r_held [2];
    logic [HELD_W-1:0] r_held_count;
    logic [HELD_W-1:0] n_held_count;
    logic              s_accept;
    logic              s_emit;
    t_group            s_group;

    // Take a byte whenever the queue has room
    assign i_byte.ready = i_queue_ready;
    assign s_accept     = i_byte.valid && i_queue_ready;
    assign s_emit       = s_accept && (i_byte.last_byte || (r_held_count == HELD_TWO));

    // Build the group from held bytes plus the incoming one
    always_comb begin
        s_group      = '0;
        s_group.last = i_byte.last_byte;
        case (r_held_count)
            HELD_NONE: begin
                s_group.b0   = i_byte.data_byte;
                s_group.code = CIN_END_ONE;
            end
            HELD_ONE: begin
                s_group.b0   = r_held[0];
                s_group.b1   = i_byte.data_byte;
                s_group.code = CIN_END_TWO;
            end
            default: begin
                s_group.b0   = r_held[0];
                s_group.b1   = r_held[1];
                s_group.b2   = i_byte.data_byte;
                s_group.code = CIN_END_THREE;
            end
        endcase
        if (!i_byte.last_byte) begin
            s_group.code = CIN_CONTINUE;
        end
    end

    assign o_push.valid = s_emit;
    assign o_push.group = s_group;

    // Advance the held count: restart after a group, else count up
    always_comb begin
        n_held_count = r_held_count;
        if (s_emit) begin
            n_held_count = HELD_NONE;
        end else if (s_accept) begin
            n_held_count = r_held_count + HELD_ONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_count <= HELD_NONE;
        end else begin
            r_held_count <= n_held_count;
        end
    end

    // Hold bytes of a partial group
    always_ff @(posedge i_clk) begin
        if (s_accept && !s_emit) begin
            r_held[r_held_count[0]] <= i_byte.data_byte;
        end
    end

endmodule

>>> rtl/sxpk_queue.sv
// Short group queue between the front end and the back end.
// Depends on sxpk_pkg for the group type and queue depth.
module sxpk_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  sxpk_pkg::t_push  i_push,
    input  logic             i_pop,
    output logic             o_ready,
    output sxpk_pkg::t_qhead o_head
);
    import sxpk_pkg::*;

    t_group            r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              s_push;
    logic              s_pop;

    assign o_ready      = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign o_head.valid = (r_count != '0);
    assign o_head.group = r_mem[r_rd_ptr];

    assign s_push = i_push.valid && o_ready;
    assign s_pop  = i_pop && o_head.valid;

    function automatic logic [QPTR_W-1:0] wrap_inc(input logic [QPTR_W-1:0] ptr);
        logic [QPTR_W-1:0] res;
        res = (ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : ptr + QPTR_W'(1);
        return res;
    endfunction

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (s_push) begin
                r_wr_ptr <= wrap_inc(r_wr_ptr);
            end
            if (s_pop) begin
                r_rd_ptr <= wrap_inc(r_rd_ptr);
            end
            if (s_push && !s_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (s_pop && !s_push) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

    // Store entries
    always_ff @(posedge i_clk) begin
        if (s_push) begin
            r_mem[r_wr_ptr] <= i_push.group;
        end
    end

endmodule

>>> rtl/sxpk_back.sv
// Back end: tracks bulk transfer fill and drives the registered event output.
// Depends on sxpk_pkg, sxpk_cfg_if and sxpk_event_if.
module sxpk_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    sxpk_cfg_if.sink         i_cfg,
    input  sxpk_pkg::t_qhead i_head,
    output logic             o_pop,
    sxpk_event_if.source     o_event
);
    import sxpk_pkg::*;

    logic [CABLE_W-1:0]  r_cable;
    logic [MAXPKT_W-1:0] r_max_pkt;
    logic [FILL_W-1:0]   r_fill;
    logic [FILL_W-1:0]   n_fill;
    logic                r_valid;
    logic [CABLE_W-1:0]  r_out_cable;
    logic [CODE_W-1:0]   r_out_code;
    logic [BYTE_W-1:0]   r_out_first;
    logic [BYTE_W-1:0]   r_out_second;
    logic [BYTE_W-1:0]   r_out_third;
    logic                r_out_end;
    logic [CMP_W-1:0]    s_limit;
    logic [CMP_W-1:0]    s_fill_sum;
    logic                s_close;

    // Configuration writes are always taken
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cable   <= '0;
            r_max_pkt <= MAXPKT_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_IDX_CABLE:  r_cable   <= i_cfg.data[CABLE_W-1:0];
                CFG_IDX_MAXPKT: r_max_pkt <= i_cfg.data[MAXPKT_W-1:0];
                default:        r_cable   <= r_cable;
            endcase
        end
    end

    // Pop when the output register is free or being drained
    assign o_pop = i_head.valid && (!r_valid || o_event.ready);

    // Clamp the transfer size and check whether this packet closes it
    assign s_limit = (CMP_W'(r_max_pkt) > CMP_W'(MAX_TRANSFER_BYTES))
                   ? CMP_W'(MAX_TRANSFER_BYTES) : CMP_W'(r_max_pkt);
    assign s_fill_sum = CMP_W'(r_fill) + CMP_W'(EVENT_BYTES);
    assign s_close    = i_head.group.last || (s_fill_sum >= s_limit);
    assign n_fill     = s_close ? '0 : s_fill_sum[FILL_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill  <= '0;
            r_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_fill  <= n_fill;
                r_valid <= 1'b1;
            end else if (o_event.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Load the output payload
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out_cable  <= r_cable;
            r_out_code   <= i_head.group.code;
            r_out_first  <= i_head.group.b0;
            r_out_second <= i_head.group.b1;
            r_out_third  <= i_head.group.b2;
            r_out_end    <= s_close;
        end
    end

    assign o_event.valid        = r_valid;
    assign o_event.cable        = r_out_cable;
    assign o_event.code_index   = r_out_code;
    assign o_event.midi_first   = r_out_first;
    assign o_event.midi_second  = r_out_second;
    assign o_event.midi_third   = r_out_third;
    assign o_event.transfer_end = r_out_end;

endmodule

>>> dv/testbench.sv
// Testbench for the SysEx event packetizer: streams messages into i_byte, predicts
// every event packet and checks o_event field by field, under several register settings.
// Depends on sxpk_pkg, the three channel interfaces and sysex_event_packetizer_top.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import sxpk_pkg::*;

    localparam int HOLD_CYCLES  = 150;
    localparam int IDLE_GAP     = 6;
    localparam int PHASE_ITEMS  = 150;
    localparam int MAX_PRINTED  = 40;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } t_sysex_byte;

    typedef struct packed {
        logic [CABLE_W-1:0] cable;
        logic [CODE_W-1:0]  code_index;
        logic [BYTE_W-1:0]  midi_first;
        logic [BYTE_W-1:0]  midi_second;
        logic [BYTE_W-1:0]  midi_third;
        logic               transfer_end;
    } t_event_pkt;

    logic i_clk;
    logic i_rst_n;

    sxpk_byte_if  in_ch ();
    sxpk_cfg_if   cfg_ch ();
    sxpk_event_if out_ch ();

    sysex_event_packetizer_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (in_ch),
        .i_cfg   (cfg_ch),
        .o_event (out_ch)
    );

    // Message bytes waiting to be offered, and event packets waiting to arrive
    t_sysex_byte sysex_bytes[$];
    t_event_pkt  predicted_events[$];
    t_sysex_byte next_byte;
    t_event_pkt  want_pkt;

    int bytes_queued;
    int bytes_taken;
    int mismatches;
    int src_idle_pct;
    int snk_idle_pct;
    int hold_left;
    int holds_done;

    // Packer state and register copies
    logic [BYTE_W-1:0]   grp_bytes [2];
    logic [HELD_W-1:0]   grp_count;
    logic [MAXPKT_W-1:0] xfer_fill;
    logic [CABLE_W-1:0]  cfg_cable;
    logic [MAXPKT_W-1:0] cfg_maxpkt;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

    task automatic report_mismatch(input string what);
        if (mismatches < MAX_PRINTED) begin
            $display("ERROR at %0t ns: %s", $time, what);
        end
        mismatches++;
    endtask

    // Group one accepted byte; push an event packet once a group closes
    task automatic pack_sysex_byte(input logic [BYTE_W-1:0] data, input logic last);
        t_event_pkt pkt;
        int lim;
        int next_fill;
        if (!last && grp_count < HELD_TWO) begin
            grp_bytes[grp_count[0]] = data;
            grp_count = grp_count + 1'b1;
            return;
        end
        pkt = '0;
        pkt.cable = cfg_cable;
        if (grp_count == HELD_NONE) begin
            pkt.midi_first = data;
        end else if (grp_count == HELD_ONE) begin
            pkt.midi_first  = grp_bytes[0];
            pkt.midi_second = data;
        end else begin
            pkt.midi_first  = grp_bytes[0];
            pkt.midi_second = grp_bytes[1];
            pkt.midi_third  = data;
        end
        if (!last) begin
            pkt.code_index = CIN_CONTINUE;
        end else if (grp_count == HELD_NONE) begin
            pkt.code_index = CIN_END_ONE;
        end else if (grp_count == HELD_ONE) begin
            pkt.code_index = CIN_END_TWO;
        end else begin
            pkt.code_index = CIN_END_THREE;
        end
        grp_count = HELD_NONE;
        // Cap the transfer size; a fill at or past it closes the transfer
        lim = (cfg_maxpkt > MAX_TRANSFER_BYTES) ? MAX_TRANSFER_BYTES : int'(cfg_maxpkt);
        next_fill = int'(xfer_fill) + EVENT_BYTES;
        pkt.transfer_end = last || (next_fill >= lim);
        xfer_fill = pkt.transfer_end ? '0 : MAXPKT_W'(next_fill);
        predicted_events.push_back(pkt);
    endtask

    task automatic push_byte(input logic [BYTE_W-1:0] data, input logic last);
        t_sysex_byte item;
        item.data = data;
        item.last = last;
        sysex_bytes.push_back(item);
        bytes_queued++;
    endtask

    // Queue one message, mostly short, sometimes long enough to span transfers
    task automatic queue_random_message();
        int len;
        int pick;
        pick = $urandom_range(99);
        if (pick < 65) begin
            len = $urandom_range(9, 1);
        end else if (pick < 95) begin
            len = $urandom_range(60, 10);
        end else begin
            len = $urandom_range(140, 61);
        end
        for (int k = 0; k < len; k++) begin
            push_byte(BYTE_W'($urandom), k == len - 1);
        end
    endtask

    // Hold until every byte is taken and every event packet has come out
    task automatic wait_until_idle();
        do @(posedge i_clk);
        while (bytes_taken != bytes_queued || predicted_events.size() != 0);
        repeat (IDLE_GAP) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(posedge i_clk);
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        cfg_ch.valid <= 1'b1;
        do @(posedge i_clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        if (idx == CFG_IDX_CABLE) begin
            cfg_cable = value[CABLE_W-1:0];
        end else begin
            cfg_maxpkt = value;
        end
    endtask

    task automatic run_random_phase(input logic [CABLE_W-1:0] cable,
                                    input logic [MAXPKT_W-1:0] maxpkt);
        int start;
        write_reg(CFG_IDX_CABLE, CFG_DATA_W'(cable));
        write_reg(CFG_IDX_MAXPKT, maxpkt);
        start = bytes_queued;
        while (bytes_queued - start < PHASE_ITEMS) begin
            queue_random_message();
        end
        wait_until_idle();
    endtask

    // Byte source: count and predict a transfer, then offer the next byte or idle
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                pack_sysex_byte(in_ch.data_byte, in_ch.last_byte);
                bytes_taken <= bytes_taken + 1;
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (sysex_bytes.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                    next_byte = sysex_bytes.pop_front();
                    in_ch.valid     <= 1'b1;
                    in_ch.data_byte <= next_byte.data;
                    in_ch.last_byte <= next_byte.last;
                end else begin
                    in_ch.valid     <= 1'b0;
                    in_ch.data_byte <= BYTE_W'($urandom);
                    in_ch.last_byte <= 1'($urandom);
                end
            end
        end
    end

    // Long receiver hold-offs, started once the source is well under way
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left  <= 0;
            holds_done <= 0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if ((holds_done == 0 && bytes_taken >= 300) ||
                     (holds_done == 1 && bytes_taken >= 960)) begin
            hold_left  <= HOLD_CYCLES;
            holds_done <= holds_done + 1;
        end
    end

    // Event sink readiness
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // Compare each event packet transfer with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (predicted_events.size() == 0) begin
                report_mismatch("event packet with nothing predicted");
            end else begin
                want_pkt = predicted_events.pop_front();
                if (out_ch.cable !== want_pkt.cable) begin
                    report_mismatch($sformatf("cable got %0h want %0h",
                                              out_ch.cable, want_pkt.cable));
                end
                if (out_ch.code_index !== want_pkt.code_index) begin
                    report_mismatch($sformatf("code_index got %0h want %0h",
                                              out_ch.code_index, want_pkt.code_index));
                end
                if (out_ch.midi_first !== want_pkt.midi_first) begin
                    report_mismatch($sformatf("midi_first got %0h want %0h",
                                              out_ch.midi_first, want_pkt.midi_first));
                end
                if (out_ch.midi_second !== want_pkt.midi_second) begin
                    report_mismatch($sformatf("midi_second got %0h want %0h",
                                              out_ch.midi_second, want_pkt.midi_second));
                end
                if (out_ch.midi_third !== want_pkt.midi_third) begin
                    report_mismatch($sformatf("midi_third got %0h want %0h",
                                              out_ch.midi_third, want_pkt.midi_third));
                end
                if (out_ch.transfer_end !== want_pkt.transfer_end) begin
                    report_mismatch($sformatf("transfer_end got %0b want %0b",
                                              out_ch.transfer_end, want_pkt.transfer_end));
                end
            end
        end
    end

    initial begin
        in_ch.valid     = 1'b0;
        in_ch.data_byte = '0;
        in_ch.last_byte = 1'b0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.index    = CFG_IDX_CABLE;
        cfg_ch.data     = '0;
        out_ch.ready    = 1'b0;
        i_rst_n         = 1'b0;
        bytes_queued    = 0;
        bytes_taken     = 0;
        mismatches      = 0;
        src_idle_pct    = 33;
        snk_idle_pct    = 87;
        grp_count       = HELD_NONE;
        xfer_fill       = '0;
        cfg_cable       = '0;
        cfg_maxpkt      = MAXPKT_RESET;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: one, two and three byte endings
        push_byte(8'h00, 1'b1);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h80, 1'b1);
        push_byte(8'hF0, 1'b0);
        push_byte(8'h7F, 1'b0);
        push_byte(8'hF7, 1'b1);
        // Full group continues, then a lone final byte
        push_byte(8'h01, 1'b0);
        push_byte(8'h02, 1'b0);
        push_byte(8'h03, 1'b0);
        push_byte(8'hFE, 1'b1);
        // Stop mid-message on a group boundary, fill at eight bytes
        push_byte(8'hAA, 1'b0);
        push_byte(8'h55, 1'b0);
        push_byte(8'hC3, 1'b0);
        push_byte(8'h3C, 1'b0);
        push_byte(8'h99, 1'b0);
        push_byte(8'h66, 1'b0);
        wait_until_idle();

        // Lower the transfer size to the fill: the next packet closes it
        write_reg(CFG_IDX_MAXPKT, 7'd8);
        push_byte(8'h11, 1'b0);
        push_byte(8'h22, 1'b0);
        push_byte(8'h33, 1'b0);
        push_byte(8'h44, 1'b1);
        wait_until_idle();

        // Sender mostly busy, receiver mostly idle
        run_random_phase(4'd15, 7'd127);
        run_random_phase(4'd0, 7'd0);

        // Sender mostly idle, receiver mostly busy
        src_idle_pct = 87;
        snk_idle_pct = 33;
        run_random_phase(4'd10, 7'd3);
        run_random_phase(4'd5, 7'd4);

        // No idling on either side
        src_idle_pct = 0;
        snk_idle_pct = 0;
        run_random_phase(CABLE_W'($urandom), 7'd64);
        run_random_phase(CABLE_W'($urandom), MAXPKT_W'($urandom_range(127)));

        repeat (10) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/sxpk_pkg.sv
rtl/sxpk_byte_if.sv
rtl/sxpk_event_if.sv
rtl/sxpk_cfg_if.sv
rtl/sxpk_front.sv
rtl/sxpk_queue.sv
rtl/sxpk_back.sv
rtl/sysex_event_packetizer_top.sv
dv/testbench.sv
